[hw/rtl/polled_feedback_slave_assert.svh]
// Assertion macros used by the core of the polled feedback slave RTL.
`ifndef POLLED_FEEDBACK_SLAVE_ASSERT_SVH
`define POLLED_FEEDBACK_SLAVE_ASSERT_SVH

// Same-cycle implication, checked on aclk outside reset.
`define PFS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("pfs assertion failed");

// Next-cycle implication, checked on aclk outside reset.
`define PFS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("pfs assertion failed");

`endif

[hw/rtl/pfs_pkg.sv]
// Types, codes and constants of the polled feedback slave.
package pfs_pkg;

    localparam logic [7:0] GOOD_CYCLE_PULSES = 8'd130;
    localparam logic [7:0] PULSE_COUNT_MAX   = 8'd255;
    localparam logic [3:0] IDLE_TICKS_MAX    = 4'd15;
    localparam logic [3:0] IDLE_CHECK_CYCLE  = 4'd3;
    localparam logic [3:0] IDLE_CHECK_PARITY = 4'd5;
    localparam logic [3:0] IDLE_CHECK_LOSS   = 4'd7;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_OWN_ADDRESS  = 2'd0,
        REG_PARITY_POLICY = 2'd1,
        REG_PULSE_POLICY = 2'd2
    } reg_index_t;

    typedef enum logic [1:0] {
        MODE_POLL  = 2'd0,
        MODE_TICK  = 2'd1,
        MODE_OFFER = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        POLICY_IGNORE       = 2'd0,
        POLICY_DROP_IF_SENT = 2'd1,
        POLICY_DROP         = 2'd2
    } policy_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] offered_byte;
    } pfs_in_t;

    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_data;
        logic        link_ok;
        logic        busy_pending;
        logic [15:0] parity_error_total;
        logic [15:0] pulse_error_total;
    } pfs_out_t;

    typedef struct packed {
        logic [7:0] own_address;
        logic [1:0] parity_policy;
        logic [1:0] pulse_policy;
    } pfs_cfg_t;

    localparam logic [1:0] PARITY_POLICY_RESET = POLICY_DROP_IF_SENT;
    localparam logic [1:0] PULSE_POLICY_RESET  = POLICY_DROP;

endpackage

[hw/rtl/pfs_cfg_regs.sv]
// Configuration register file of the polled feedback slave.
module pfs_cfg_regs
    import pfs_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data,
    output pfs_cfg_t               cfg
);

    pfs_cfg_t cfg_reg;
    pfs_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_OWN_ADDRESS:   cfg_next.own_address   = cfg_wr_data;
                REG_PARITY_POLICY: cfg_next.parity_policy = cfg_wr_data[1:0];
                REG_PULSE_POLICY:  cfg_next.pulse_policy  = cfg_wr_data[1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.own_address   <= '0;
            cfg_reg.parity_policy <= PARITY_POLICY_RESET;
            cfg_reg.pulse_policy  <= PULSE_POLICY_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[hw/rtl/pfs_in_stage.sv]
// Input register of the polled feedback slave.
module pfs_in_stage
    import pfs_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  pfs_in_t s_item,
    input  logic    advance,
    output logic    item_valid,
    output pfs_in_t item
);

    logic    valid_reg;
    logic    valid_next;
    pfs_in_t item_reg;

    assign s_ready    = !valid_reg || advance;
    assign valid_next = s_ready ? s_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

[hw/rtl/pfs_core.sv]
// Bus state, pulse counting, silence checks and error policies.
module pfs_core
    import pfs_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  pfs_cfg_t cfg,
    input  logic     fire,
    input  pfs_in_t  item,
    output pfs_out_t result
);

`include "polled_feedback_slave_assert.svh"

    logic [7:0]  pulse_count_reg, pulse_count_next;
    logic [7:0]  last_seen_reg, last_seen_next;
    logic [3:0]  idle_ticks_reg, idle_ticks_next;
    logic [7:0]  held_byte_reg, held_byte_next;
    logic        pending_reg, pending_next;
    logic        armed_reg, armed_next;
    logic        sent_reg, sent_next;
    logic        retry_pulse_reg, retry_pulse_next;
    logic        retry_parity_reg, retry_parity_next;
    logic        good_reg, good_next;
    logic [15:0] parity_errors_reg, parity_errors_next;
    logic [15:0] pulse_errors_reg, pulse_errors_next;
    logic        tx_valid;
    logic [7:0]  tx_data;
    logic        poll_step;
    logic        quiet_tick;

    function automatic logic policy_drops(input logic [1:0] policy, input logic just_sent);
        logic drop;
        case (policy)
            POLICY_DROP_IF_SENT: drop = just_sent;
            POLICY_DROP:         drop = 1'b1;
            default:             drop = 1'b0;
        endcase
        return drop;
    endfunction

    always_comb begin
        pulse_count_next   = pulse_count_reg;
        last_seen_next     = last_seen_reg;
        idle_ticks_next    = idle_ticks_reg;
        held_byte_next     = held_byte_reg;
        pending_next       = pending_reg;
        armed_next         = armed_reg;
        sent_next          = sent_reg;
        retry_pulse_next   = retry_pulse_reg;
        retry_parity_next  = retry_parity_reg;
        good_next          = good_reg;
        parity_errors_next = parity_errors_reg;
        pulse_errors_next  = pulse_errors_reg;
        tx_valid           = 1'b0;
        tx_data            = '0;
        case (item.mode)
            MODE_POLL: begin
                if (armed_reg && (cfg.own_address == pulse_count_reg)) begin
                    tx_valid     = 1'b1;
                    tx_data      = held_byte_reg;
                    pending_next = 1'b0;
                    armed_next   = 1'b0;
                    sent_next    = 1'b1;
                end
                if (pulse_count_reg != PULSE_COUNT_MAX) begin
                    pulse_count_next = pulse_count_reg + 8'd1;
                end
            end
            MODE_TICK: begin
                if (pulse_count_reg != last_seen_reg) begin
                    last_seen_next  = pulse_count_reg;
                    idle_ticks_next = 4'd1;
                end else if (idle_ticks_reg != IDLE_TICKS_MAX) begin
                    idle_ticks_next = idle_ticks_reg + 4'd1;
                    if (idle_ticks_next == IDLE_CHECK_CYCLE) begin
                        retry_pulse_next  = sent_reg;
                        retry_parity_next = sent_reg;
                        sent_next         = 1'b0;
                        if (pulse_count_reg == GOOD_CYCLE_PULSES) begin
                            good_next = 1'b1;
                            if (pending_reg) begin
                                armed_next = 1'b1;
                            end
                        end else if (good_reg) begin
                            pulse_errors_next = pulse_errors_reg + 16'd1;
                            if (policy_drops(cfg.pulse_policy, sent_reg)) begin
                                good_next  = 1'b0;
                                armed_next = 1'b0;
                            end
                        end
                        pulse_count_next = '0;
                        last_seen_next   = '0;
                    end else if (idle_ticks_next == IDLE_CHECK_PARITY) begin
                        if (good_reg) begin
                            parity_errors_next = parity_errors_reg + 16'd1;
                            if (policy_drops(cfg.parity_policy, retry_parity_reg)) begin
                                good_next  = 1'b0;
                                armed_next = 1'b0;
                            end
                        end
                    end else if (idle_ticks_next == IDLE_CHECK_LOSS) begin
                        if (good_reg) begin
                            parity_errors_next = parity_errors_reg - 16'd1;
                        end
                        good_next  = 1'b0;
                        armed_next = 1'b0;
                    end
                end
            end
            MODE_OFFER: begin
                if (!pending_reg) begin
                    held_byte_next = item.offered_byte;
                    pending_next   = 1'b1;
                end
            end
            default: begin
                tx_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pulse_count_reg   <= '0;
            last_seen_reg     <= '0;
            idle_ticks_reg    <= '0;
            held_byte_reg     <= '0;
            pending_reg       <= 1'b0;
            armed_reg         <= 1'b0;
            sent_reg          <= 1'b0;
            retry_pulse_reg   <= 1'b0;
            retry_parity_reg  <= 1'b0;
            good_reg          <= 1'b0;
            parity_errors_reg <= '0;
            pulse_errors_reg  <= '0;
        end else if (fire) begin
            pulse_count_reg   <= pulse_count_next;
            last_seen_reg     <= last_seen_next;
            idle_ticks_reg    <= idle_ticks_next;
            held_byte_reg     <= held_byte_next;
            pending_reg       <= pending_next;
            armed_reg         <= armed_next;
            sent_reg          <= sent_next;
            retry_pulse_reg   <= retry_pulse_next;
            retry_parity_reg  <= retry_parity_next;
            good_reg          <= good_next;
            parity_errors_reg <= parity_errors_next;
            pulse_errors_reg  <= pulse_errors_next;
        end
    end

    assign result.tx_valid           = tx_valid;
    assign result.tx_data            = tx_data;
    assign result.link_ok            = good_next;
    assign result.busy_pending       = pending_next;
    assign result.parity_error_total = parity_errors_next;
    assign result.pulse_error_total  = pulse_errors_next;

    assign poll_step  = fire && (item.mode == MODE_POLL) && (pulse_count_reg != PULSE_COUNT_MAX);
    assign quiet_tick = fire && (item.mode == MODE_TICK) && (idle_ticks_reg == IDLE_TICKS_MAX)
                        && (pulse_count_reg == last_seen_reg);

    `PFS_ASSERT_SAME(a_armed_needs_link, armed_reg, good_reg)
    `PFS_ASSERT_SAME(a_armed_needs_pending, armed_reg, pending_reg)
    `PFS_ASSERT_SAME(a_tx_only_on_poll, fire && tx_valid, item.mode == MODE_POLL)
    `PFS_ASSERT_NEXT(a_poll_counts, poll_step, pulse_count_reg == 8'($past(pulse_count_reg) + 8'd1))
    `PFS_ASSERT_NEXT(a_long_silence_quiet, quiet_tick, $stable(parity_errors_reg) && $stable(good_reg))

endmodule

[hw/rtl/pfs_out_stage.sv]
// Result register of the polled feedback slave.
module pfs_out_stage
    import pfs_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     load,
    input  pfs_out_t result,
    output logic     can_load,
    output logic     m_valid,
    input  logic     m_ready,
    output pfs_out_t m_result
);

    logic     valid_reg;
    logic     valid_next;
    pfs_out_t result_reg;

    assign can_load   = !valid_reg || m_ready;
    assign valid_next = load ? 1'b1 : (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = result_reg;

endmodule

[hw/rtl/polled_feedback_slave.sv]
// Top level of the polled feedback slave.
//
// Input channel s_valid/s_ready/s_item: one transaction is one bus event
// (poll pulse, tick or a byte offered by software). Result channel
// m_valid/m_ready/m_result: exactly one transaction per input transaction,
// in order, holding tx_valid/tx_data for the pulse and the link status,
// pending flag and both error counters after the event.
// Configuration: cfg_wr_en writes cfg_wr_data into register cfg_index
// (0 own address, 1 parity policy, 2 pulse policy) at the clock edge;
// write only while no transaction is in flight.
// The accepting edge loads the input register; the state update is loaded
// into the result register once it can take the item, and m_valid is set
// by that load. Throughput is one transaction per cycle while the receiver
// does not stall.
// When the receiver stalls, the result register holds; the input register
// takes a transaction only while empty, so s_ready drops once it holds one.
// Reset (aresetn low, synchronous) empties both registers, clears all bus
// state and counters and loads the policy reset values.
module polled_feedback_slave
    import pfs_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  pfs_in_t                s_item,
    output logic                   m_valid,
    input  logic                   m_ready,
    output pfs_out_t               m_result,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data
);

    pfs_cfg_t cfg;
    pfs_in_t  item;
    pfs_out_t result;
    logic     item_valid;
    logic     can_load;
    logic     advance;

    assign advance = item_valid && can_load;

    pfs_cfg_regs u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    pfs_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    pfs_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .fire    (advance),
        .item    (item),
        .result  (result)
    );

    pfs_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance),
        .result   (result),
        .can_load (can_load),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

endmodule
